// ----- hdl/host_address_pool_allocator_top_macros.svh -----
// Assertion macros for the host address pool allocator.
// Included by the modules that check their own logic; no other dependencies.
`ifndef HOST_ADDRESS_POOL_ALLOCATOR_TOP_MACROS_SVH
`define HOST_ADDRESS_POOL_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset
`define HAPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hapa assertion failed");
// Next-cycle implication, disabled in reset
`define HAPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hapa assertion failed");
`else
`define HAPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HAPA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/hapa_pkg.sv -----
// Shared types and constants of the host address pool allocator.
// No dependencies; imported by every module of the block except hapa_ram.
package hapa_pkg;

	localparam int unsigned DEVICE_SLOTS_DEF = 256;
	localparam int unsigned FIRST_HOST_DEF   = 2;
	localparam int unsigned LAST_HOST_DEF    = 254;

	localparam int unsigned RING_DEPTH = 256;
	localparam int unsigned RING_AW    = 8;
	localparam int unsigned HOST_W     = 8;
	localparam int unsigned DEV_ID_W   = 8;
	localparam int unsigned PREFIX_W   = 24;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned COUNT_W    = 9;

	localparam logic [PREFIX_W-1:0] PREFIX_RESET = {8'd192, 8'd168, 8'd1};

	// Operation codes
	localparam logic FUNC_CONNECT    = 1'b0;
	localparam logic FUNC_DISCONNECT = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_CONN = 3'd4;

	typedef struct packed {
		logic                func;
		logic [DEV_ID_W-1:0] device_id;
	} alloc_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   ip_address;
	} alloc_rsp_t;

	// Commands from the controller to the free ring
	typedef struct packed {
		logic               fill;
		logic [RING_AW-1:0] fill_idx;
		logic               rd;
		logic               pop;
		logic               push;
		logic [HOST_W-1:0]  push_host;
	} ring_ctl_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
	} ring_stat_t;

endpackage

// ----- hdl/hapa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hapa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/hapa_slot_map.sv -----
// Maps a device number onto its slot of the device table (number mod slots).
// Depends on hapa_pkg.
module hapa_slot_map #(
	parameter int unsigned DEVICE_SLOTS = hapa_pkg::DEVICE_SLOTS_DEF
) (
	input  logic [hapa_pkg::DEV_ID_W-1:0]   device_id,
	output logic [$clog2(DEVICE_SLOTS)-1:0] slot
);

	import hapa_pkg::*;

	localparam int unsigned SlotW  = $clog2(DEVICE_SLOTS);
	localparam int unsigned IdSpan = 1 << DEV_ID_W;

	logic [SlotW-1:0] slot_tab [IdSpan];

	// Build the constant remainder table at elaboration
	for (genvar g = 0; g < IdSpan; g++) begin : g_tab
		localparam int unsigned SlotVal = g % DEVICE_SLOTS;
		assign slot_tab[g] = SlotW'(SlotVal);
	end

	assign slot = slot_tab[device_id];

endmodule

// ----- hdl/hapa_ring.sv -----
// Free list of host numbers: ring memory with head, tail and fill count.
// Depends on hapa_pkg and hapa_ram.
module hapa_ring #(
	parameter int unsigned FIRST_HOST = hapa_pkg::FIRST_HOST_DEF,
	parameter int unsigned LAST_HOST  = hapa_pkg::LAST_HOST_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hapa_pkg::ring_ctl_t         ctl,
	output logic [hapa_pkg::HOST_W-1:0] head_host,
	output hapa_pkg::ring_stat_t        stat
);

	import hapa_pkg::*;

	localparam int unsigned HostSpan =
		(LAST_HOST >= FIRST_HOST) ? (LAST_HOST - FIRST_HOST + 1) : 0;

	logic [RING_AW-1:0] head_q;
	logic [RING_AW-1:0] tail_q;
	logic [COUNT_W-1:0] count_q;
	logic               full;
	logic               push_ok;
	logic               we;
	logic [RING_AW-1:0] waddr;
	logic [HOST_W-1:0]  wdata;
	logic [HOST_W-1:0]  fill_val;

	assign full    = (count_q == COUNT_W'(RING_DEPTH));
	assign push_ok = ctl.push && !full;

	// Initial contents: ascending host numbers, zero past the span
	assign fill_val = (COUNT_W'(ctl.fill_idx) < COUNT_W'(HostSpan))
		? (HOST_W'(FIRST_HOST) + HOST_W'(ctl.fill_idx)) : '0;

	// Select sweep write or tail write
	assign we    = ctl.fill || push_ok;
	assign waddr = ctl.fill ? ctl.fill_idx : tail_q;
	assign wdata = ctl.fill ? fill_val : ctl.push_host;

	hapa_ram #(
		.WIDTH(HOST_W),
		.DEPTH(RING_DEPTH)
	) u_ring_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.rd),
		.raddr(head_q),
		.rdata(head_host)
	);

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= RING_AW'(HostSpan % RING_DEPTH);
			count_q <= COUNT_W'(HostSpan);
		end else begin
			if (ctl.pop) begin
				head_q  <= head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end else if (push_ok) begin
				tail_q  <= tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign stat.count = count_q;

endmodule

// ----- hdl/host_address_pool_allocator_top.sv -----
// Top level of the host address pool allocator: control, device table, prefix.
// Depends on hapa_pkg, hapa_ram, hapa_slot_map, hapa_ring and the macro header.
`include "host_address_pool_allocator_top_macros.svh"
//
// Usage:
// Request channel: start with req {func, device_id}; an item is taken at a
// rising edge where start is high and busy is low. func connect binds a free
// host to the device, func disconnect returns it to the tail of the pool.
// Result channel: done is high for one cycle with rsp {status, ip_address};
// there is no backpressure, the result must be taken in that cycle.
// Configuration: cfg_valid / cfg_ready / cfg_data write the 24-bit network
// prefix; cfg_ready is always high. Write it only while the block is idle.
// An item taken moves the controller to S_EXEC; the result is registered
// there into done and rsp. No new item is taken until the current one has
// left S_EXEC, as the device table and ring memories are read, then updated.
// Reset: busy stays high while a sweep over max(256, DEVICE_SLOTS) entries
// loads the ring with the host numbers and clears the device table; the
// prefix returns to 192.168.1.
module host_address_pool_allocator_top #(
	parameter int unsigned DEVICE_SLOTS = hapa_pkg::DEVICE_SLOTS_DEF,
	parameter int unsigned FIRST_HOST   = hapa_pkg::FIRST_HOST_DEF,
	parameter int unsigned LAST_HOST    = hapa_pkg::LAST_HOST_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  hapa_pkg::alloc_req_t          req,
	output logic                          busy,
	output logic                          done,
	output hapa_pkg::alloc_rsp_t          rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hapa_pkg::PREFIX_W-1:0] cfg_data
);

	import hapa_pkg::*;

	localparam int unsigned SlotW      = $clog2(DEVICE_SLOTS);
	localparam int unsigned SweepDepth =
		(DEVICE_SLOTS > RING_DEPTH) ? DEVICE_SLOTS : RING_DEPTH;
	localparam int unsigned SweepW     = $clog2(SweepDepth);
	localparam int unsigned DevW       = HOST_W + 1;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t              state_q;
	logic [SweepW-1:0]   sweep_q;
	logic                func_q;
	logic [SlotW-1:0]    slot_q;
	logic                done_q;
	alloc_rsp_t          rsp_q;
	logic [PREFIX_W-1:0] prefix_q;

	logic                accept;
	logic [SlotW-1:0]    slot;
	logic                sweep_last;
	logic                ring_fill;
	logic                dev_clear;

	logic                dev_we;
	logic [SlotW-1:0]    dev_waddr;
	logic [DevW-1:0]     dev_wdata;
	logic [DevW-1:0]     dev_rdata;
	logic                dev_valid;
	logic [HOST_W-1:0]   dev_host;

	ring_ctl_t           ring_ctl;
	ring_stat_t          ring_stat;
	logic [HOST_W-1:0]   ring_host;

	logic [STATUS_W-1:0] exec_status;
	logic [HOST_W-1:0]   exec_host;
	logic                exec_addr_en;
	logic                exec_pop;
	logic                exec_push;
	logic                exec_dev_we;
	logic                exec_dev_valid;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Hold the network prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PREFIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			prefix_q <= cfg_data;
		end
	end

	hapa_slot_map #(
		.DEVICE_SLOTS(DEVICE_SLOTS)
	) u_slot_map (
		.device_id(req.device_id),
		.slot     (slot)
	);

	// Sweep range checks for the two memories
	assign sweep_last = ((SweepW + 1)'(sweep_q) == (SweepW + 1)'(SweepDepth - 1));
	assign ring_fill  = (state_q == S_INIT) &&
		((SweepW + 1)'(sweep_q) < (SweepW + 1)'(RING_DEPTH));
	assign dev_clear  = (state_q == S_INIT) &&
		((SweepW + 1)'(sweep_q) < (SweepW + 1)'(DEVICE_SLOTS));

	assign dev_valid = dev_rdata[DevW-1];
	assign dev_host  = dev_rdata[HOST_W-1:0];

	// Decide the outcome from the table entry and the ring head
	always_comb begin
		exec_status    = ST_NOT_CONN;
		exec_host      = dev_host;
		exec_addr_en   = 1'b0;
		exec_pop       = 1'b0;
		exec_push      = 1'b0;
		exec_dev_we    = 1'b0;
		exec_dev_valid = 1'b0;
		unique case (func_q)
			FUNC_CONNECT: begin
				if (dev_valid) begin
					exec_status  = ST_ALREADY;
					exec_addr_en = 1'b1;
				end else if (ring_stat.count == '0) begin
					exec_status = ST_EMPTY;
				end else begin
					exec_status    = ST_NEW;
					exec_host      = ring_host;
					exec_addr_en   = 1'b1;
					exec_pop       = 1'b1;
					exec_dev_we    = 1'b1;
					exec_dev_valid = 1'b1;
				end
			end
			FUNC_DISCONNECT: begin
				if (dev_valid) begin
					exec_status  = ST_RELEASED;
					exec_addr_en = 1'b1;
					exec_push    = 1'b1;
					exec_dev_we  = 1'b1;
				end
			end
			default: begin
				exec_status = ST_NOT_CONN;
			end
		endcase
	end

	// Device table: sweep clear or update after the read
	assign dev_we    = dev_clear || ((state_q == S_EXEC) && exec_dev_we);
	assign dev_waddr = dev_clear ? sweep_q[SlotW-1:0] : slot_q;
	assign dev_wdata = dev_clear ? '0 : {exec_dev_valid, exec_host};

	hapa_ram #(
		.WIDTH(DevW),
		.DEPTH(DEVICE_SLOTS)
	) u_dev_ram (
		.clk  (clk),
		.we   (dev_we),
		.waddr(dev_waddr),
		.wdata(dev_wdata),
		.re   (accept),
		.raddr(slot),
		.rdata(dev_rdata)
	);

	// Ring commands
	always_comb begin
		ring_ctl.fill      = ring_fill;
		ring_ctl.fill_idx  = sweep_q[RING_AW-1:0];
		ring_ctl.rd        = accept;
		ring_ctl.pop       = (state_q == S_EXEC) && exec_pop;
		ring_ctl.push      = (state_q == S_EXEC) && exec_push;
		ring_ctl.push_host = dev_host;
	end

	hapa_ring #(
		.FIRST_HOST(FIRST_HOST),
		.LAST_HOST (LAST_HOST)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ring_ctl),
		.head_host(ring_host),
		.stat     (ring_stat)
	);

	// Sequence sweep, accept and update; register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
			func_q  <= FUNC_CONNECT;
			slot_q  <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						func_q  <= req.func;
						slot_q  <= slot;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q           <= 1'b1;
					rsp_q.status     <= exec_status;
					rsp_q.ip_address <= exec_addr_en ? {prefix_q, exec_host} : '0;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`HAPA_ASSERT_NXT(a_accept_to_exec, clk, arst_n, accept, state_q == S_EXEC)
	`HAPA_ASSERT_NXT(a_exec_gives_done, clk, arst_n, state_q == S_EXEC, done)
	`HAPA_ASSERT_IMP(a_no_addr_on_fail, clk, arst_n, done && (rsp.status == ST_EMPTY || rsp.status == ST_NOT_CONN), rsp.ip_address == '0)
	`HAPA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, ring_stat.count <= COUNT_W'(RING_DEPTH))

endmodule

// ----- dv/host_address_pool_allocator_top_test.sv -----
// Self-checking testbench for host_address_pool_allocator_top: connect and disconnect items
// are checked against a predictor of the host free list and device table.
// Depends on hapa_pkg and the RTL of the block.
module host_address_pool_allocator_top_test;
	import hapa_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int TIMEOUT_CYCLES = 200000;

	typedef enum logic [1:0] {STEP_ITEM, STEP_PREFIX, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		alloc_req_t            req;
		logic [PREFIX_W-1:0]   prefix;
		bit                    may_idle;
	} step_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	alloc_req_t          req       = '0;
	logic                busy;
	logic                done;
	alloc_rsp_t          rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [PREFIX_W-1:0] cfg_data  = '0;

	// Stimulus plan and driver bookkeeping
	step_t req_plan[$];
	bit    idle_ok;
	int    inflight;
	logic  nxt_start;
	logic  nxt_cfg;

	// Predictor state: free host list, device table, prefix
	logic [HOST_W-1:0]   free_hosts [0:RING_DEPTH-1];
	logic [RING_AW-1:0]  pool_rd;
	logic [RING_AW-1:0]  pool_wr;
	logic [COUNT_W-1:0]  pool_free;
	bit                  dev_bound [0:DEVICE_SLOTS_DEF-1];
	logic [HOST_W-1:0]   dev_host  [0:DEVICE_SLOTS_DEF-1];
	logic [PREFIX_W-1:0] prefix_q;

	// Checking state
	alloc_rsp_t rsp_due[$];
	alloc_rsp_t want;
	int         mismatches;
	int         items_taken;
	int         prefix_writes;
	int         status_seen [0:7];

	host_address_pool_allocator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Work out the result of one item and advance the pool and device table
	function automatic alloc_rsp_t predict_lease(alloc_req_t r);
		alloc_rsp_t        o;
		int                slot;
		logic [HOST_W-1:0] host;
		o = '0;
		slot = int'(r.device_id) % DEVICE_SLOTS_DEF;
		if (r.func == FUNC_CONNECT) begin
			if (dev_bound[slot]) begin
				o.status = ST_ALREADY;
				o.ip_address = {prefix_q, dev_host[slot]};
			end else if (pool_free == 0) begin
				o.status = ST_EMPTY;
			end else begin
				host = free_hosts[pool_rd];
				pool_rd = pool_rd + 1'b1;
				pool_free = pool_free - 1'b1;
				dev_host[slot] = host;
				dev_bound[slot] = 1'b1;
				o.status = ST_NEW;
				o.ip_address = {prefix_q, host};
			end
		end else begin
			if (dev_bound[slot]) begin
				host = dev_host[slot];
				dev_bound[slot] = 1'b0;
				// a full list drops the host
				if (pool_free < RING_DEPTH) begin
					free_hosts[pool_wr] = host;
					pool_wr = pool_wr + 1'b1;
					pool_free = pool_free + 1'b1;
				end
				o.status = ST_RELEASED;
				o.ip_address = {prefix_q, host};
			end else begin
				o.status = ST_NOT_CONN;
			end
		end
		return o;
	endfunction

	task automatic plan_req(input logic f, input logic [DEV_ID_W-1:0] id);
		step_t s;
		s.kind = STEP_ITEM;
		s.req.func = f;
		s.req.device_id = id;
		s.prefix = '0;
		s.may_idle = idle_ok;
		req_plan.insert(req_plan.size(), s);
	endtask

	task automatic plan_prefix(input logic [PREFIX_W-1:0] value);
		step_t s;
		s.kind = STEP_PREFIX;
		s.req = '0;
		s.prefix = value;
		s.may_idle = 1'b0;
		req_plan.insert(req_plan.size(), s);
	endtask

	// Driver: present planned items and prefix writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			inflight = 0;
		end else begin
			// retire what the block took at this edge
			if (start && !busy) begin
				inflight++;
				void'(req_plan.pop_front());
			end
			if (done)
				inflight--;
			if (cfg_valid && cfg_ready)
				void'(req_plan.pop_front());

			// hold a pending handshake, else pick the next step
			nxt_start = start && busy;
			nxt_cfg = cfg_valid && !cfg_ready;
			if (!nxt_start && !nxt_cfg && req_plan.size() > 0) begin
				case (req_plan[0].kind)
					STEP_ITEM: begin
						if (!(req_plan[0].may_idle && $urandom_range(99) < 28)) begin
							nxt_start = 1'b1;
							req <= req_plan[0].req;
						end
					end
					STEP_PREFIX: begin
						// write only once the block is idle
						if (inflight == 0 && !busy) begin
							nxt_cfg = 1'b1;
							cfg_data <= req_plan[0].prefix;
						end
					end
					STEP_DRAIN: begin
						if (inflight == 0)
							void'(req_plan.pop_front());
					end
					default: ;
				endcase
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// Monitor: check each result, then predict the item taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++)
				free_hosts[i] = '0;
			pool_free = '0;
			for (int h = FIRST_HOST_DEF; h <= LAST_HOST_DEF && pool_free < RING_DEPTH; h++) begin
				free_hosts[pool_free[RING_AW-1:0]] = h[HOST_W-1:0];
				pool_free = pool_free + 1'b1;
			end
			pool_rd = '0;
			pool_wr = pool_free[RING_AW-1:0];
			for (int i = 0; i < DEVICE_SLOTS_DEF; i++) begin
				dev_bound[i] = 1'b0;
				dev_host[i] = '0;
			end
			prefix_q = PREFIX_RESET;
			rsp_due.delete();
		end else begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					$error("result with nothing outstanding: status %0d ip_address %h",
						rsp.status, rsp.ip_address);
					mismatches++;
				end else begin
					want = rsp_due.pop_front();
					status_seen[want.status]++;
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.ip_address !== want.ip_address) begin
						$error("ip_address: expected %h, actual %h",
							want.ip_address, rsp.ip_address);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				prefix_q = cfg_data;
				prefix_writes++;
			end
			if (start && !busy) begin
				rsp_due.insert(rsp_due.size(), predict_lease(req));
				items_taken++;
			end
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("host_address_pool_allocator_top_test: errors");
		$finish;
	end

	initial begin
		int   order [0:255];
		int   j;
		int   tmp;
		step_t pause;

		// Directed: reset prefix, rebinding, unknown releases, FIFO reuse
		idle_ok = 1'b1;
		plan_req(FUNC_CONNECT, 8'd0);
		plan_req(FUNC_CONNECT, 8'd0);
		plan_req(FUNC_CONNECT, 8'd255);
		plan_req(FUNC_DISCONNECT, 8'd0);
		plan_req(FUNC_DISCONNECT, 8'd0);
		plan_req(FUNC_DISCONNECT, 8'd128);
		plan_req(FUNC_CONNECT, 8'd0);
		plan_req(FUNC_CONNECT, 8'd128);
		plan_req(FUNC_DISCONNECT, 8'd255);
		plan_req(FUNC_CONNECT, 8'd255);
		plan_req(FUNC_DISCONNECT, 8'd255);
		plan_req(FUNC_DISCONNECT, 8'd128);
		plan_req(FUNC_DISCONNECT, 8'd0);
		plan_req(FUNC_CONNECT, 8'd170);
		plan_req(FUNC_CONNECT, 8'd85);
		plan_req(FUNC_DISCONNECT, 8'd170);
		plan_req(FUNC_DISCONNECT, 8'd85);
		plan_prefix(24'hFFFFFF);
		plan_req(FUNC_CONNECT, 8'd1);
		plan_req(FUNC_CONNECT, 8'd254);
		plan_req(FUNC_DISCONNECT, 8'd1);
		plan_req(FUNC_DISCONNECT, 8'd254);
		plan_prefix(24'h000000);

		// Random mix over a small device set so releases hit bound devices
		for (int i = 0; i < 150; i++)
			plan_req($urandom_range(1) == 1,
				DEV_ID_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(31)));

		// Exhaust the pool: connect every device in shuffled order, then some more
		plan_prefix(24'hFFFFFF);
		for (int i = 0; i < 256; i++)
			order[i] = i;
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 256; i++)
			plan_req(FUNC_CONNECT, DEV_ID_W'(order[i]));
		for (int i = 0; i < 12; i++)
			plan_req(FUNC_CONNECT, DEV_ID_W'($urandom_range(255)));

		// Back to back, release-heavy, with one full drain in the middle
		plan_prefix(PREFIX_W'($urandom_range(24'hFFFFFF)));
		idle_ok = 1'b0;
		for (int i = 0; i < 200; i++) begin
			if (i == 100) begin
				pause.kind = STEP_DRAIN;
				pause.req = '0;
				pause.prefix = '0;
				pause.may_idle = 1'b0;
				req_plan.insert(req_plan.size(), pause);
			end
			plan_req($urandom_range(99) < 60, DEV_ID_W'($urandom_range(255)));
		end

		// Random mix again with gaps
		plan_prefix(PREFIX_W'($urandom_range(24'hFFFFFF)));
		idle_ok = 1'b1;
		for (int i = 0; i < 180; i++)
			plan_req($urandom_range(1) == 1,
				DEV_ID_W'(($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(63)));

		// Release reset and let the plan run out
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (req_plan.size() == 0 && inflight == 0 && !start && !cfg_valid);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (rsp_due.size() != 0) begin
			$error("%0d results never arrived", rsp_due.size());
			mismatches++;
		end

		$display("Checked %0d requests under %0d prefix writes,", items_taken, prefix_writes);
		$display("with the pool run dry and refilled.");
		$display("Statuses: new %0d, already %0d, empty %0d, released %0d, not connected %0d",
			status_seen[ST_NEW], status_seen[ST_ALREADY], status_seen[ST_EMPTY],
			status_seen[ST_RELEASED], status_seen[ST_NOT_CONN]);
		if (mismatches == 0) begin
			$display("host_address_pool_allocator_top_test: clean");
		end else begin
			$display("host_address_pool_allocator_top_test: errors");
		end
		$finish;
	end

endmodule
